// ----- rtl/core/qpll_pkg.sv -----
// shared types, constants and microprogram for the quadrature pll
package qpll_pkg;

  localparam logic [24:0] TURN      = 25'd16777216;
  localparam logic [24:0] HALF_TURN = 25'd8388608;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  // round(2*pi*2^30) is even, so half of it fits 32 bits unsigned
  localparam logic [31:0] TWO_PI_HALF = 32'd3373259426;
  localparam logic [30:0] MAG_MAX     = 31'h7fffffff;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_NOMINAL_FREQ  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SAMPLE_PERIOD = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_PROP_GAIN     = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INTEG_GAIN    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_FREQ_LIMIT    = 3'd4;

  typedef logic [4:0] op_t;

  localparam op_t OP_AA  = 5'd0;   // |alpha|^2
  localparam op_t OP_BB  = 5'd1;   // |beta|^2, starts the root
  localparam op_t OP_AC  = 5'd2;   // alpha * last cos
  localparam op_t OP_BS  = 5'd3;   // beta * last sin, half-turn jump
  localparam op_t OP_FT  = 5'd4;   // angle advance
  localparam op_t OP_X   = 5'd5;   // octant angle to radians
  localparam op_t OP_X2  = 5'd6;
  localparam op_t OP_D72 = 5'd7;
  localparam op_t OP_D42 = 5'd8;
  localparam op_t OP_D20 = 5'd9;
  localparam op_t OP_D6  = 5'd10;
  localparam op_t OP_D90 = 5'd11;
  localparam op_t OP_D56 = 5'd12;
  localparam op_t OP_D30 = 5'd13;
  localparam op_t OP_D12 = 5'd14;
  localparam op_t OP_D2  = 5'd15;  // last cosine term, builds cos/sin
  localparam op_t OP_QM  = 5'd16;  // x2 * t
  localparam op_t OP_SX  = 5'd17;  // x * t, octant sine
  localparam op_t OP_CB  = 5'd18;
  localparam op_t OP_SA  = 5'd19;  // phase error
  localparam op_t OP_UP  = 5'd20;  // proportional term
  localparam op_t OP_UI  = 5'd21;  // integrator and clamp

  localparam int PCW = 5;
  localparam logic [PCW-1:0] PROG_LAST = 5'd27;

  typedef struct packed {
    logic load;
    logic issue;
    op_t  op;
    logic load_out;
  } qpll_cmd_t;

  typedef struct packed {
    logic root_done;
  } qpll_stat_t;

  function automatic op_t prog_op(input logic [PCW-1:0] pc);
    op_t o;
    unique case (pc)
      5'd0:  o = OP_AA;
      5'd1:  o = OP_BB;
      5'd2:  o = OP_AC;
      5'd3:  o = OP_BS;
      5'd4:  o = OP_FT;
      5'd5:  o = OP_X;
      5'd6:  o = OP_X2;
      5'd7:  o = OP_D72;
      5'd8:  o = OP_QM;
      5'd9:  o = OP_D42;
      5'd10: o = OP_QM;
      5'd11: o = OP_D20;
      5'd12: o = OP_QM;
      5'd13: o = OP_D6;
      5'd14: o = OP_SX;
      5'd15: o = OP_D90;
      5'd16: o = OP_QM;
      5'd17: o = OP_D56;
      5'd18: o = OP_QM;
      5'd19: o = OP_D30;
      5'd20: o = OP_QM;
      5'd21: o = OP_D12;
      5'd22: o = OP_QM;
      5'd23: o = OP_D2;
      5'd24: o = OP_CB;
      5'd25: o = OP_SA;
      5'd26: o = OP_UP;
      5'd27: o = OP_UI;
      default: o = OP_UI;
    endcase
    return o;
  endfunction

  function automatic logic [6:0] div_den(input op_t op);
    logic [6:0] d;
    unique case (op)
      OP_D72: d = 7'd72;
      OP_D42: d = 7'd42;
      OP_D20: d = 7'd20;
      OP_D6:  d = 7'd6;
      OP_D90: d = 7'd90;
      OP_D56: d = 7'd56;
      OP_D30: d = 7'd30;
      OP_D12: d = 7'd12;
      OP_D2:  d = 7'd2;
      default: d = 7'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / d)
  function automatic logic [31:0] div_rcp(input op_t op);
    logic [31:0] m;
    unique case (op)
      OP_D72: m = 32'd59652323;
      OP_D42: m = 32'd102261126;
      OP_D20: m = 32'd214748364;
      OP_D6:  m = 32'd715827882;
      OP_D90: m = 32'd47721858;
      OP_D56: m = 32'd76695844;
      OP_D30: m = 32'd143165576;
      OP_D12: m = 32'd357913941;
      OP_D2:  m = 32'd2147483648;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/qpll_if.sv -----
// channel interfaces of the quadrature pll
interface qpll_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_alpha;
  logic signed [31:0] sample_beta;
  logic               run;
  modport source (output valid, sample_alpha, sample_beta, run, input ready);
  modport sink (input valid, sample_alpha, sample_beta, run, output ready);
endinterface

interface qpll_out_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] cos_out;
  logic signed [25:0] sin_out;
  logic [24:0]        angle_out;
  logic signed [31:0] freq_out;
  logic [30:0]        magnitude;
  logic signed [31:0] phase_error;
  logic signed [31:0] pi_drive;
  modport source (output valid, cos_out, sin_out, angle_out, freq_out, magnitude,
                  phase_error, pi_drive, input ready);
  modport sink (input valid, cos_out, sin_out, angle_out, freq_out, magnitude,
                phase_error, pi_drive, output ready);
endinterface

interface qpll_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/quadrature_phase_locked_loop.sv -----
// quadrature pll top level: channels, sequencer and datapath
//
// in_ch carries one alpha/beta sample in Q24 and a run flag; out_ch returns
// cos, sin, angle, frequency, magnitude, phase error and PI drive for it.
// cfg_ch writes the five loop registers by index; it is always ready.
// It must be written only while no sample is in flight; the block itself
// does not enforce this. A sample runs as 28 micro-operations on the
// single shared 33x33 multiplier (issue, then writeback), then loads the
// output register. The square root runs beside the multiplier program.
// A new sample is accepted only once the previous one has been loaded
// into the output register.
// The result sits in an output register, so in_ch.ready returns as soon as
// a sample finishes, even while the previous word waits on out_ch. If the
// receiver still holds the old word when the next one is done, the block
// waits with in_ch.ready low until it is taken.
// Reset clears the configuration, the angle, last cos/sin, the integrator
// and the PI output, and empties the output register.
module quadrature_phase_locked_loop (
  input  logic       clk,
  input  logic       rst_n,
  qpll_in_if.sink    in_ch,
  qpll_out_if.source out_ch,
  qpll_cfg_if.sink   cfg_ch
);

  qpll_pkg::qpll_cmd_t  cmd;
  qpll_pkg::qpll_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  qpll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  qpll_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .smp_alpha (in_ch.sample_alpha),
    .smp_beta  (in_ch.sample_beta),
    .smp_run   (in_ch.run),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .o_cos     (out_ch.cos_out),
    .o_sin     (out_ch.sin_out),
    .o_angle   (out_ch.angle_out),
    .o_freq    (out_ch.freq_out),
    .o_mag     (out_ch.magnitude),
    .o_perr    (out_ch.phase_error),
    .o_pi      (out_ch.pi_drive)
  );

endmodule

// ----- rtl/core/qpll_isqrt.sv -----
// bit-pair integer square root, one result bit per cycle
module qpll_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] v_r, v_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      v_nxt    = value;
      res_nxt  = 64'd0;
      bit_nxt  = 64'd1 << 62;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign root = res_r[31:0];
  assign done = done_r;

endmodule

// ----- rtl/core/qpll_ctrl.sv -----
// sequencer: steps the datapath through the per-sample microprogram
module qpll_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output qpll_pkg::qpll_cmd_t   cmd,
  input  qpll_pkg::qpll_stat_t  stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [qpll_pkg::PCW-1:0] pc_r, pc_nxt;
  logic                     ph_r, ph_nxt;
  logic                     full_r, full_nxt;
  logic                     load_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = full_r;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ph_nxt    = ph_r;
    load_out  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
          pc_nxt    = '0;
          ph_nxt    = 1'b0;
        end
      end
      ST_RUN: begin
        // even cycle issues a multiply, odd cycle writes it back
        if (!ph_r) begin
          cmd.issue = 1'b1;
          cmd.op    = qpll_pkg::prog_op(pc_r);
          ph_nxt    = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (pc_r == qpll_pkg::PROG_LAST) begin
            state_nxt = ST_FIN;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (stat.root_done && (!full_r || out_ready)) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    cmd.load_out = load_out;
  end

  always_comb begin
    full_nxt = full_r;
    if (load_out) begin
      full_nxt = 1'b1;
    end else if (out_ready) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      ph_r    <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ph_r    <= ph_nxt;
      full_r  <= full_nxt;
    end
  end

endmodule

// ----- rtl/core/qpll_datapath.sv -----
// registers, shared multiplier and writeback logic of the pll
module qpll_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qpll_pkg::qpll_cmd_t         cmd,
  output qpll_pkg::qpll_stat_t        stat,
  input  logic signed [31:0]          smp_alpha,
  input  logic signed [31:0]          smp_beta,
  input  logic                        smp_run,
  input  logic                        cfg_we,
  input  logic [qpll_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic signed [25:0]          o_cos,
  output logic signed [25:0]          o_sin,
  output logic [24:0]                 o_angle,
  output logic signed [31:0]          o_freq,
  output logic [30:0]                 o_mag,
  output logic signed [31:0]          o_perr,
  output logic signed [31:0]          o_pi
);

  // configuration
  logic signed [31:0] nom_r, sp_r, kp_r, ki_r;
  logic [30:0]        lim_r;

  // loop state
  logic [24:0]        angle_r, angle_nxt;
  logic signed [25:0] cs_r, sn_r;
  logic signed [31:0] integ_r, pi_r;

  // sample and scratch
  logic signed [31:0] a_r, b_r;
  logic               run_r;
  logic               neg1_r;
  logic signed [31:0] freq_r, e1_r, delt_r, up_r;
  logic [30:0]        x_r, x2_r, v_r, t_r;
  logic [24:0]        so_r;
  logic [63:0]        sq_r;

  // multiplier pipe
  logic signed [65:0] p_r;
  qpll_pkg::op_t      wop_r;
  logic               wbv_r;

  logic               root_done;
  logic [31:0]        root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r <= '0;
      sp_r  <= '0;
      kp_r  <= '0;
      ki_r  <= '0;
      lim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qpll_pkg::CFG_NOMINAL_FREQ:  nom_r <= cfg_data;
        qpll_pkg::CFG_SAMPLE_PERIOD: sp_r  <= cfg_data;
        qpll_pkg::CFG_PROP_GAIN:     kp_r  <= cfg_data;
        qpll_pkg::CFG_INTEG_GAIN:    ki_r  <= cfg_data;
        qpll_pkg::CFG_FREQ_LIMIT:    lim_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // absolute values; the most negative word maps to 2^31
  logic [31:0] aa, bb;
  assign aa = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign bb = b_r[31] ? (~b_r + 32'd1) : b_r;

  // fold the angle to an octant
  logic [23:0] u;
  logic [1:0]  quad;
  logic [21:0] f, r_oct;
  logic        swap;
  assign u     = angle_r[23:0];
  assign quad  = u[23:22];
  assign f     = u[21:0];
  assign swap  = (f > 22'h200000);
  assign r_oct = swap ? 22'(23'h400000 - {1'b0, f}) : f;

  // divide operand: first term of each series takes x2
  logic [30:0] dv_iss, dv_wb;
  assign dv_iss = (cmd.op == qpll_pkg::OP_D72 || cmd.op == qpll_pkg::OP_D90) ? x2_r : v_r;
  assign dv_wb  = (wop_r == qpll_pkg::OP_D72 || wop_r == qpll_pkg::OP_D90) ? x2_r : v_r;

  logic signed [32:0] ma, mb;
  logic signed [32:0] cs_x, sn_x, a_x, b_x;
  assign cs_x = {{7{cs_r[25]}}, cs_r};
  assign sn_x = {{7{sn_r[25]}}, sn_r};
  assign a_x  = {a_r[31], a_r};
  assign b_x  = {b_r[31], b_r};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      qpll_pkg::OP_AA: begin ma = {1'b0, aa}; mb = {1'b0, aa}; end
      qpll_pkg::OP_BB: begin ma = {1'b0, bb}; mb = {1'b0, bb}; end
      qpll_pkg::OP_AC: begin ma = a_x; mb = cs_x; end
      qpll_pkg::OP_BS: begin ma = b_x; mb = sn_x; end
      qpll_pkg::OP_FT: begin
        ma = {freq_r[31], freq_r};
        mb = {{5{sp_r[31]}}, sp_r[31:4]};
      end
      qpll_pkg::OP_X: begin
        ma = {11'd0, r_oct};
        mb = {1'b0, qpll_pkg::TWO_PI_HALF};
      end
      qpll_pkg::OP_X2: begin ma = {2'b0, x_r}; mb = {2'b0, x_r}; end
      qpll_pkg::OP_D72, qpll_pkg::OP_D42, qpll_pkg::OP_D20, qpll_pkg::OP_D6,
      qpll_pkg::OP_D90, qpll_pkg::OP_D56, qpll_pkg::OP_D30, qpll_pkg::OP_D12,
      qpll_pkg::OP_D2: begin
        ma = {2'b0, dv_iss};
        mb = {1'b0, qpll_pkg::div_rcp(cmd.op)};
      end
      qpll_pkg::OP_QM: begin ma = {2'b0, x2_r}; mb = {2'b0, t_r}; end
      qpll_pkg::OP_SX: begin ma = {2'b0, x_r}; mb = {2'b0, t_r}; end
      qpll_pkg::OP_CB: begin ma = cs_x; mb = b_x; end
      qpll_pkg::OP_SA: begin ma = sn_x; mb = a_x; end
      qpll_pkg::OP_UP: begin
        ma = {{5{delt_r[31]}}, delt_r[31:4]};
        mb = {kp_r[31], kp_r};
      end
      qpll_pkg::OP_UI: begin ma = {up_r[31], up_r}; mb = {ki_r[31], ki_r}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbv_r <= 1'b0;
    end else begin
      wbv_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      p_r   <= ma * mb;
      wop_r <= cmd.op;
    end
  end

  // writeback arithmetic
  logic signed [31:0] p24, adv;
  assign p24 = p_r[55:24];
  assign adv = {p_r[47:20], 4'b0};

  logic signed [33:0] vsum, vm1;
  assign vsum = {9'd0, angle_r} + {{2{adv[31]}}, adv};
  assign vm1  = vsum - 34'sd1;

  always_comb begin
    if (vsum > 34'sd16777216) begin
      angle_nxt = {1'b0, vm1[23:0]} + 25'd1;
    end else if (vsum < 34'sd0) begin
      angle_nxt = {1'b0, vsum[23:0]};
    end else begin
      angle_nxt = vsum[24:0];
    end
  end

  // constant divide: reciprocal product, then one correction step
  logic [30:0] q0, q;
  logic [6:0]  den;
  logic [37:0] rem;
  logic [30:0] t_new;
  assign q0    = p_r[62:32];
  assign den   = qpll_pkg::div_den(wop_r);
  assign rem   = {7'd0, dv_wb} - ({7'd0, q0} * {31'd0, den});
  assign q     = (rem >= {31'd0, den}) ? q0 + 31'd1 : q0;
  assign t_new = qpll_pkg::ONE_Q30 - q;

  logic [31:0] co_sum, so_sum;
  logic [24:0] co, so;
  assign co_sum = {1'b0, t_new} + 32'd32;
  assign co     = co_sum[30:6];
  assign so_sum = {1'b0, p_r[60:30]} + 32'd32;
  assign so     = so_sum[30:6];

  logic signed [25:0] sc0, ss0, cs_nxt, sn_nxt;
  assign sc0 = swap ? {1'b0, so_r} : {1'b0, co};
  assign ss0 = swap ? {1'b0, co} : {1'b0, so_r};

  always_comb begin
    unique case (quad)
      2'd0: begin cs_nxt = sc0;  sn_nxt = ss0;  end
      2'd1: begin cs_nxt = -ss0; sn_nxt = sc0;  end
      2'd2: begin cs_nxt = -sc0; sn_nxt = -ss0; end
      default: begin cs_nxt = ss0; sn_nxt = -sc0; end
    endcase
  end

  // loop filter
  logic signed [31:0] isum, integ_nxt, pisum, pi_nxt;
  logic signed [32:0] pe, lime;
  assign isum      = (integ_r >>> 4) + p_r[51:20];
  assign integ_nxt = {isum[27:0], 4'b0};
  assign pisum     = up_r + integ_nxt;
  assign pe        = {pisum[31], pisum};
  assign lime      = {2'b0, lim_r};

  always_comb begin
    if (pe > lime) begin
      pi_nxt = {1'b0, lim_r};
    end else if (pe < -lime) begin
      pi_nxt = 32'(-lime);
    end else begin
      pi_nxt = pisum;
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      cs_r    <= '0;
      sn_r    <= '0;
      integ_r <= '0;
      pi_r    <= '0;
    end else begin
      if (cmd.load && !smp_run) begin
        integ_r <= '0;
        pi_r    <= '0;
      end
      if (wbv_r) begin
        unique case (wop_r)
          qpll_pkg::OP_BS: begin
            if (run_r && neg1_r && p24[31]) begin
              angle_r <= angle_r + qpll_pkg::HALF_TURN;
            end
          end
          qpll_pkg::OP_FT: angle_r <= angle_nxt;
          qpll_pkg::OP_D2: begin
            cs_r <= cs_nxt;
            sn_r <= sn_nxt;
          end
          qpll_pkg::OP_UI: begin
            integ_r <= integ_nxt;
            pi_r    <= pi_nxt;
          end
          default: ;
        endcase
      end
    end
  end

  // sample and scratch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r   <= smp_alpha;
      b_r   <= smp_beta;
      run_r <= smp_run;
    end
    if (wbv_r) begin
      unique case (wop_r)
        qpll_pkg::OP_AA: sq_r <= p_r[63:0];
        qpll_pkg::OP_AC: neg1_r <= p24[31];
        qpll_pkg::OP_BS: freq_r <= nom_r + (pi_r >>> 4);
        qpll_pkg::OP_X:  x_r <= p_r[53:23];
        qpll_pkg::OP_X2: x2_r <= p_r[60:30];
        qpll_pkg::OP_D72, qpll_pkg::OP_D42, qpll_pkg::OP_D20, qpll_pkg::OP_D6,
        qpll_pkg::OP_D90, qpll_pkg::OP_D56, qpll_pkg::OP_D30, qpll_pkg::OP_D12,
        qpll_pkg::OP_D2: t_r <= t_new;
        qpll_pkg::OP_QM: v_r <= p_r[60:30];
        qpll_pkg::OP_SX: so_r <= so;
        qpll_pkg::OP_CB: e1_r <= p24;
        qpll_pkg::OP_SA: delt_r <= e1_r - p24;
        qpll_pkg::OP_UP: up_r <= adv;
        default: ;
      endcase
    end
  end

  // magnitude runs beside the rest of the program
  logic        root_go;
  logic [63:0] root_val;
  assign root_go  = wbv_r && (wop_r == qpll_pkg::OP_BB);
  assign root_val = sq_r + p_r[63:0];

  qpll_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_go),
    .value (root_val),
    .root  (root),
    .done  (root_done)
  );

  assign stat.root_done = root_done;

  logic [31:0] mx0, mx;
  assign mx0 = (root > aa) ? root : aa;
  assign mx  = (mx0 > bb) ? mx0 : bb;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_cos   <= cs_r;
      o_sin   <= sn_r;
      o_angle <= angle_r;
      o_freq  <= freq_r;
      o_mag   <= (mx > {1'b0, qpll_pkg::MAG_MAX}) ? qpll_pkg::MAG_MAX : mx[30:0];
      o_perr  <= delt_r;
      o_pi    <= pi_r;
    end
  end

endmodule

// ----- dv/quadrature_phase_locked_loop_tb.sv -----
// testbench for the quadrature pll: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module quadrature_phase_locked_loop_tb;

  localparam int LIMIT_CYCLES = 3000000;
  localparam logic [qpll_pkg::CFG_IW-1:0] CFG_UNUSED_IDX = 3'd5;
  localparam longint TURN_L = 64'd16777216;
  localparam longint HALF_L = 64'd8388608;
  localparam longint unsigned ONE_L = 64'd1073741824;
  localparam longint unsigned TWO_PI_L = 64'd6746518852;

  typedef struct {
    logic signed [25:0] cos_v;
    logic signed [25:0] sin_v;
    logic [24:0]        angle_v;
    logic signed [31:0] freq_v;
    logic [30:0]        mag_v;
    logic signed [31:0] perr_v;
    logic signed [31:0] pi_v;
  } loop_word_t;

  typedef struct {
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic               run;
    bit                 typed;
    loop_word_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  qpll_in_if  in_ch ();
  qpll_out_if out_ch ();
  qpll_cfg_if cfg_ch ();

  quadrature_phase_locked_loop dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // loop registers and state as tracked by the predictor
  longint nom_freq, samp_period, kp, ki, clamp_lim;
  longint ph_angle, prev_cos, prev_sin, integ_acc, pi_hold;

  loop_word_t pending_words[$];
  int errors = 0;
  int cycles = 0;
  int hold_reqs = 0;
  bit calm = 1'b0;

  function automatic longint s32(input longint v);
    return longint'(int'(v));
  endfunction

  function automatic longint mpy_q(input longint a, input longint b, input int n);
    return s32((a * b) >>> n);
  endfunction

  function automatic longint shl4(input longint v);
    return s32(v << 4);
  endfunction

  function automatic longint unsigned qm(input longint unsigned a,
                                         input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic void octant_trig(input longint unsigned r, output longint s,
                                      output longint c);
    longint unsigned x, x2, t;
    x  = (r * TWO_PI_L) >> 24;
    x2 = qm(x, x);
    t = ONE_L - x2 / 72;
    t = ONE_L - qm(x2, t) / 42;
    t = ONE_L - qm(x2, t) / 20;
    t = ONE_L - qm(x2, t) / 6;
    s = longint'((qm(x, t) + 32) >> 6);
    t = ONE_L - x2 / 90;
    t = ONE_L - qm(x2, t) / 56;
    t = ONE_L - qm(x2, t) / 30;
    t = ONE_L - qm(x2, t) / 12;
    t = ONE_L - qm(x2, t) / 2;
    c = longint'((t + 32) >> 6);
  endfunction

  function automatic void turn_trig(input longint a, output longint s, output longint c);
    longint unsigned u, f;
    longint s0, c0;
    int q;
    u = longint'(a) & (TURN_L - 1);
    q = int'(u >> 22);
    f = u & 64'h3fffff;
    if (f <= 64'h200000) octant_trig(f, s0, c0);
    else octant_trig(64'h400000 - f, c0, s0);
    case (q)
      0: begin c = c0; s = s0; end
      1: begin c = -s0; s = c0; end
      2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic loop_word_t track_loop(input logic signed [31:0] alpha,
                                            input logic signed [31:0] beta,
                                            input logic run);
    longint a, b, freq, v, cs, sn, delt, up;
    longint unsigned aa, bb, mag;
    loop_word_t w;
    a = alpha;
    b = beta;
    if (!run) begin
      pi_hold = 0;
      integ_acc = 0;
    end
    // both products negative: input sits opposite the tracked vector
    if (run && mpy_q(a, prev_cos, 24) < 0 && mpy_q(b, prev_sin, 24) < 0)
      ph_angle += HALF_L;
    freq = s32(nom_freq + (pi_hold >>> 4));
    v = ph_angle + shl4(mpy_q(freq, samp_period >>> 4, 20));
    if (v > TURN_L) v = ((v - 1) % TURN_L) + 1;
    else if (v < 0) v = ((v % TURN_L) + TURN_L) % TURN_L;
    ph_angle = v;
    turn_trig(ph_angle, sn, cs);
    prev_cos = cs;
    prev_sin = sn;
    aa = longint'(a < 0 ? -a : a);
    bb = longint'(b < 0 ? -b : b);
    mag = int_root(aa * aa + bb * bb);
    if (mag < aa) mag = aa;
    if (mag < bb) mag = bb;
    if (mag > 64'h7fffffff) mag = 64'h7fffffff;
    delt = s32(mpy_q(cs, b, 24) - mpy_q(sn, a, 24));
    up = shl4(mpy_q(delt >>> 4, kp, 20));
    integ_acc = shl4(s32((integ_acc >>> 4) + mpy_q(up, ki, 20)));
    pi_hold = s32(up + integ_acc);
    if (pi_hold > clamp_lim) pi_hold = clamp_lim;
    if (pi_hold < -clamp_lim) pi_hold = -clamp_lim;
    w.cos_v   = cs[25:0];
    w.sin_v   = sn[25:0];
    w.angle_v = ph_angle[24:0];
    w.freq_v  = freq[31:0];
    w.mag_v   = mag[30:0];
    w.perr_v  = delt[31:0];
    w.pi_v    = pi_hold[31:0];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // scoreboard on the result channel
  always @(posedge clk) begin
    loop_word_t w;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        w = pending_words.pop_front();
        if (out_ch.cos_out !== w.cos_v) report_mismatch("cos_out", out_ch.cos_out, w.cos_v);
        if (out_ch.sin_out !== w.sin_v) report_mismatch("sin_out", out_ch.sin_out, w.sin_v);
        if (out_ch.angle_out !== w.angle_v)
          report_mismatch("angle_out", out_ch.angle_out, w.angle_v);
        if (out_ch.freq_out !== w.freq_v)
          report_mismatch("freq_out", out_ch.freq_out, w.freq_v);
        if (out_ch.magnitude !== w.mag_v)
          report_mismatch("magnitude", out_ch.magnitude, w.mag_v);
        if (out_ch.phase_error !== w.perr_v)
          report_mismatch("phase_error", out_ch.phase_error, w.perr_v);
        if (out_ch.pi_drive !== w.pi_v)
          report_mismatch("pi_drive", out_ch.pi_drive, w.pi_v);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure, with long hold-offs on request
  initial begin
    int stall;
    int holds_seen;
    int r;
    stall = 0;
    holds_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        stall = 400;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ch.ready <= 1'b1;
        end else if (r < 97) begin
          out_ch.ready <= 1'b0;
          stall = $urandom_range(0, 4);
        end else begin
          out_ch.ready <= 1'b0;
          stall = $urandom_range(20, 150);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic send_word(input logic signed [31:0] alpha, input logic signed [31:0] beta,
                           input logic run, input bit typed, input loop_word_t want,
                           input int gap);
    loop_word_t w;
    in_ch.valid        <= 1'b1;
    in_ch.sample_alpha <= alpha;
    in_ch.sample_beta  <= beta;
    in_ch.run          <= run;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    w = track_loop(alpha, beta, run);
    pending_words.push_back(typed ? want : w);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [qpll_pkg::CFG_IW-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      qpll_pkg::CFG_NOMINAL_FREQ:  nom_freq = longint'(signed'(val));
      qpll_pkg::CFG_SAMPLE_PERIOD: samp_period = longint'(signed'(val));
      qpll_pkg::CFG_PROP_GAIN:     kp = longint'(signed'(val));
      qpll_pkg::CFG_INTEG_GAIN:    ki = longint'(signed'(val));
      qpll_pkg::CFG_FREQ_LIMIT:    clamp_lim = longint'({1'b0, val[30:0]});
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] nf, input logic [31:0] sp,
                           input logic [31:0] p, input logic [31:0] i,
                           input logic [31:0] lim);
    drain();
    write_reg(qpll_pkg::CFG_NOMINAL_FREQ, nf);
    write_reg(qpll_pkg::CFG_SAMPLE_PERIOD, sp);
    write_reg(qpll_pkg::CFG_PROP_GAIN, p);
    write_reg(qpll_pkg::CFG_INTEG_GAIN, i);
    write_reg(qpll_pkg::CFG_FREQ_LIMIT, lim);
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'd0;
      3: return $urandom();
      default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_sample(input int amp);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'(int'($urandom_range(0, 2 * amp)) - amp);
    endcase
  endfunction

  initial begin
    stim_row_t reset_rows[$];
    stim_row_t tune_rows[$];
    stim_row_t row;
    loop_word_t none;
    int amp;
    int phase_len;
    logic signed [31:0] a, b;

    none = '{default: '0};
    in_ch.valid = 1'b0;
    in_ch.sample_alpha = '0;
    in_ch.sample_beta = '0;
    in_ch.run = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    nom_freq = 0; samp_period = 0; kp = 0; ki = 0; clamp_lim = 0;
    ph_angle = 0; prev_cos = 0; prev_sin = 0; integ_acc = 0; pi_hold = 0;

    // with all registers zero the angle stays put: cos is one, sin zero,
    // so the phase error is beta itself
    reset_rows.push_back('{32'sd0, 32'sd0, 1'b1, 1'b1,
                           '{26'sd16777216, 26'sd0, 25'd0, 32'sd0, 31'd0, 32'sd0, 32'sd0}});
    reset_rows.push_back('{32'sd50331648, 32'sd67108864, 1'b1, 1'b1,
                           '{26'sd16777216, 26'sd0, 25'd0, 32'sd0, 31'd83886080,
                             32'sd67108864, 32'sd0}});
    reset_rows.push_back('{32'sh80000000, 32'sd0, 1'b0, 1'b1,
                           '{26'sd16777216, 26'sd0, 25'd0, 32'sd0, 31'h7fffffff,
                             32'sd0, 32'sd0}});
    reset_rows.push_back('{32'sd0, 32'sh80000000, 1'b1, 1'b1,
                           '{26'sd16777216, 26'sd0, 25'd0, 32'sd0, 31'h7fffffff,
                             32'sh80000000, 32'sd0}});
    reset_rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b1,
                           '{26'sd16777216, 26'sd0, 25'd0, 32'sd0, 31'h7fffffff,
                             32'sh7fffffff, 32'sd0}});
    reset_rows.push_back('{32'sh80000000, 32'sh80000000, 1'b1, 1'b1,
                           '{26'sd16777216, 26'sd0, 25'd0, 32'sd0, 31'h7fffffff,
                             32'sh80000000, 32'sd0}});

    // eighth-turn steps; the opposite-quadrant rows force the half-turn jump
    tune_rows.push_back('{32'sd16777216, 32'sd0, 1'b1, 1'b0, none});
    tune_rows.push_back('{-32'sd16777216, -32'sd16777216, 1'b1, 1'b0, none});
    tune_rows.push_back('{32'sd11863283, 32'sd11863283, 1'b1, 1'b0, none});
    tune_rows.push_back('{-32'sd16777216, -32'sd16777216, 1'b0, 1'b0, none});
    tune_rows.push_back('{32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0, none});
    tune_rows.push_back('{32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0, none});
    tune_rows.push_back('{32'sd0, 32'sd16777216, 1'b1, 1'b0, none});
    tune_rows.push_back('{32'sd16777216, -32'sd16777216, 1'b1, 1'b0, none});
    tune_rows.push_back('{-32'sd33554432, 32'sd33554432, 1'b1, 1'b0, none});
    tune_rows.push_back('{32'sd1, -32'sd1, 1'b0, 1'b0, none});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (reset_rows[k]) begin
      row = reset_rows[k];
      send_word(row.alpha, row.beta, row.run, row.typed, row.want, pick_gap());
    end

    load_regs(32'd131072, 32'd16777216, 32'd1048576, 32'd65536, 32'd16777216);
    write_reg(CFG_UNUSED_IDX, 32'hffffffff);
    foreach (tune_rows[k]) begin
      row = tune_rows[k];
      send_word(row.alpha, row.beta, row.run, 1'b0, none, pick_gap());
    end

    load_regs(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    foreach (tune_rows[k]) begin
      row = tune_rows[k];
      send_word(row.alpha, row.beta, row.run, 1'b0, none, pick_gap());
    end

    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0)
        load_regs(32'(int'($urandom_range(0, 1 << 19)) - (1 << 18)),
                  32'(int'($urandom_range(1 << 22, 1 << 25))),
                  32'(int'($urandom_range(0, 1 << 22))),
                  32'(int'($urandom_range(0, 1 << 18))),
                  ph == 3 ? 32'd0 : 32'(int'($urandom_range(1 << 20, 1 << 26))));
      else
        load_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
      calm = (ph == 4);
      phase_len = 130;
      amp = (ph % 2 == 0) ? (1 << 25) : (1 << 27);
      for (int n = 0; n < phase_len; n++) begin
        // hold off the receiver while samples keep coming back to back
        if (ph == 2 && n == 20) hold_reqs++;
        a = pick_sample(amp);
        b = pick_sample(amp);
        send_word(a, b, ($urandom_range(0, 15) != 0), 1'b0, none,
                  (ph == 2 && n >= 20 && n < 32) ? 0 : pick_gap());
      end
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/qpll_pkg.sv
rtl/core/qpll_if.sv
rtl/core/qpll_isqrt.sv
rtl/core/qpll_ctrl.sv
rtl/core/qpll_datapath.sv
rtl/core/quadrature_phase_locked_loop.sv
dv/quadrature_phase_locked_loop_tb.sv
